// ----- hdl/eafd_pkg.sv -----
package eafd_pkg;

    localparam int DEGREE_FRACTION_BITS = 12;

    localparam int BYTE_W     = 8;
    localparam int ANGLE_BITS = 21;
    localparam int STATUS_W   = 3;
    localparam int PAYLOAD_W  = 3 * BYTE_W;
    localparam int POS_W      = 3;

    localparam int DEG_SCALE   = 360;
    localparam int DEG_SCALE_W = $clog2(DEG_SCALE + 1);
    localparam int PROD_W      = ANGLE_BITS + DEG_SCALE_W;
    localparam int DEG_SHIFT   = ANGLE_BITS - DEGREE_FRACTION_BITS;

    localparam logic [BYTE_W-1:0]     CRC_POLY   = 8'h07;
    localparam logic [BYTE_W-1:0]     CRC_INIT   = 8'h00;
    localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = {ANGLE_BITS{1'b1}};

    // position within the frame
    localparam logic [POS_W-1:0] POS_CMD0 = 3'd0;
    localparam logic [POS_W-1:0] POS_B2   = 3'd2;
    localparam logic [POS_W-1:0] POS_B4   = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC  = 3'd5;
    localparam logic [POS_W-1:0] POS_DONE = 3'd6;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_count;
        logic [STATUS_W-1:0]   status_bits;
        logic [BYTE_W-1:0]     crc_received;
        logic [BYTE_W-1:0]     crc_computed;
        logic                  crc_match;
        logic                  frame_error;
        logic [ANGLE_BITS-1:0] angle_degrees;
    } result_t;

    // msb-first crc-8, one byte unrolled
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // raw * 360 >> (21 - fraction bits), saturating at 21 bits
    function automatic logic [ANGLE_BITS-1:0] to_degrees(input logic [ANGLE_BITS-1:0] raw);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] deg;
        prod = PROD_W'(raw) * PROD_W'(DEG_SCALE);
        deg  = prod >> DEG_SHIFT;
        if (|deg[PROD_W-1:ANGLE_BITS])
            return ANGLE_MASK;
        return deg[ANGLE_BITS-1:0];
    endfunction

endpackage

// ----- hdl/eafd_item_if.sv -----
interface eafd_item_if;
    import eafd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_first;

    modport source (output valid, output rx_byte, output frame_first, input ready);
    modport sink   (input valid, input rx_byte, input frame_first, output ready);
endinterface

// ----- hdl/eafd_result_if.sv -----
interface eafd_result_if;
    import eafd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle_count;
    logic [STATUS_W-1:0]   status_bits;
    logic [BYTE_W-1:0]     crc_received;
    logic [BYTE_W-1:0]     crc_computed;
    logic                  crc_match;
    logic                  frame_error;
    logic [ANGLE_BITS-1:0] angle_degrees;

    modport source (output valid, output angle_count, output status_bits,
                    output crc_received, output crc_computed, output crc_match,
                    output frame_error, output angle_degrees, input ready);
    modport sink   (input valid, input angle_count, input status_bits,
                    input crc_received, input crc_computed, input crc_match,
                    input frame_error, input angle_degrees, output ready);
endinterface

// ----- hdl/encoder_angle_frame_decoder_top.sv -----
// angle burst frame decoder with crc-8 check
//
// item channel: one received byte per transfer, frame_first marks byte 0 of
// a frame. bytes 0 and 1 are skipped, bytes 2 to 4 carry angle and status,
// byte 5 is the crc sent by the sensor.
// result channel: one transfer per complete frame, registered; valid rises
// the cycle after the crc byte is taken.
// throughput: one byte per cycle while no result waits on a stalled
// receiver. the byte-wide unrolled crc step updates the frame crc; the 21x9
// degrees multiply lies between the frame state and the result register.
// the item side keeps taking bytes while the result register is empty or
// being drained in the same cycle; while a result waits on a stalled
// receiver, item ready is low and the result holds.
// config: cfg_we writes cfg_data into check_enable (reset value 1).
// reset clears the frame position, crc and payload, empties the result
// register and sets check_enable; the first frame after reset decodes from
// its first byte even without the frame_first mark.
module encoder_angle_frame_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    eafd_item_if.sink            item,
    eafd_result_if.source        result
);
    import eafd_pkg::*;

    logic    check_enable_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    accept;
    logic    emit;
    result_t frame_result;

    assign item.ready = ~out_valid_reg | result.ready;
    assign accept     = item.valid & item.ready;

    eafd_frame_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (item.rx_byte),
        .frame_first  (item.frame_first),
        .check_enable (check_enable_reg),
        .emit         (emit),
        .result       (frame_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            check_enable_reg <= 1'b1;
        else if (cfg_we)
            check_enable_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= frame_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.angle_count   = out_reg.angle_count;
    assign result.status_bits   = out_reg.status_bits;
    assign result.crc_received  = out_reg.crc_received;
    assign result.crc_computed  = out_reg.crc_computed;
    assign result.crc_match     = out_reg.crc_match;
    assign result.frame_error   = out_reg.frame_error;
    assign result.angle_degrees = out_reg.angle_degrees;

endmodule

// ----- hdl/eafd_frame_track.sv -----
module eafd_frame_track (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [eafd_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           frame_first,
    input  logic                           check_enable,
    output logic                           emit,
    output eafd_pkg::result_t              result
);
    import eafd_pkg::*;

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [BYTE_W-1:0]    crc_reg;
    logic [BYTE_W-1:0]    crc_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;

    logic [POS_W-1:0]     pos;
    logic [BYTE_W-1:0]    crc_base;
    logic [PAYLOAD_W-1:0] payload_base;
    logic                 match;

    always_comb
    begin
        pos          = frame_first ? POS_CMD0 : pos_reg;
        crc_base     = (pos == POS_CMD0) ? CRC_INIT : crc_reg;
        payload_base = (pos == POS_CMD0) ? '0 : payload_reg;
        crc_next     = crc_base;
        payload_next = payload_base;
        if (pos inside {[POS_B2:POS_B4]})
        begin
            crc_next     = crc8_byte(crc_base, rx_byte);
            payload_next = {payload_base[PAYLOAD_W-BYTE_W-1:0], rx_byte};
        end
        if (pos >= POS_CRC)
            pos_next = POS_DONE;
        else
            pos_next = pos + POS_W'(1);
    end

    // at the crc byte the payload is already complete in payload_reg
    assign emit  = (pos == POS_CRC);
    assign match = (crc_reg == rx_byte);

    always_comb
    begin
        result.angle_count   = payload_reg[PAYLOAD_W-1:STATUS_W];
        result.status_bits   = payload_reg[STATUS_W-1:0];
        result.crc_received  = rx_byte;
        result.crc_computed  = crc_reg;
        result.crc_match     = match;
        result.frame_error   = check_enable & ~match;
        result.angle_degrees = to_degrees(payload_reg[PAYLOAD_W-1:STATUS_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_CMD0;
            crc_reg     <= CRC_INIT;
            payload_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            payload_reg <= payload_next;
        end
    end

endmodule

// ----- hdl/eafd_checker.sv -----
module eafd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [eafd_pkg::BYTE_W-1:0]      crc_received,
    input logic [eafd_pkg::BYTE_W-1:0]      crc_computed,
    input logic                             crc_match,
    input logic                             frame_error,
    input logic [eafd_pkg::ANGLE_BITS-1:0]  angle_count
);
    import eafd_pkg::*;

    // a result only follows a byte transfer
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_valid && item_ready))
        else $error("result appeared without an item transfer");

    // empty result register never blocks the item side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("item side stalled with no result pending");

    a_match_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (crc_match == (crc_computed == crc_received)))
        else $error("crc match flag disagrees with crc values");

    a_no_error_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && crc_match) |-> !frame_error)
        else $error("frame error raised on matching crc");

    // stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(angle_count)))
        else $error("stalled result changed");

endmodule

bind encoder_angle_frame_decoder_top eafd_checker u_eafd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .crc_received (result.crc_received),
    .crc_computed (result.crc_computed),
    .crc_match    (result.crc_match),
    .frame_error  (result.frame_error),
    .angle_count  (result.angle_count)
);
